/* rtl/core/scg_pkg.sv */
// ----------------------------------------------------------------------------
// scg_pkg - shared types and constants for the Scharr gradient block
// Default geometry limits, register indexes and the 3-10-3 kernel sum.
// ----------------------------------------------------------------------------
`default_nettype none

package scg_pkg;

  // Default geometry limits
  localparam int unsigned MaxWidthDef    = 1024;
  localparam int unsigned MaxChannelsDef = 4;
  localparam int unsigned MaxHeightDef   = 1024;

  // Configuration port widths
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 11;

  // Payload widths
  localparam int unsigned PixelW = 8;
  localparam int unsigned GradW  = 13;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    RegImageWidth   = 2'd0,
    RegImageHeight  = 2'd1,
    RegChannelCount = 2'd2
  } cfg_reg_e;

  // One source column of the 3x3 window
  typedef struct packed {
    logic [PixelW-1:0] top;
    logic [PixelW-1:0] mid;
    logic [PixelW-1:0] bot;
  } win_col_t;

  // Two previous columns kept per channel
  typedef struct packed {
    win_col_t left;
    win_col_t cent;
  } win_pair_t;

  // Difference of two samples, 9-bit signed
  function automatic logic signed [PixelW:0] pix_diff(input logic [PixelW-1:0] a,
                                                      input logic [PixelW-1:0] b);
    pix_diff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // 3*a + 10*b + 3*c, constant weights as shift-and-add
  function automatic logic signed [GradW-1:0] kernel_sum(input logic signed [PixelW:0] a,
                                                         input logic signed [PixelW:0] b,
                                                         input logic signed [PixelW:0] c);
    logic signed [GradW-1:0] ax;
    logic signed [GradW-1:0] bx;
    logic signed [GradW-1:0] cx;
    ax = GradW'(a);
    bx = GradW'(b);
    cx = GradW'(c);
    kernel_sum = (ax <<< 1) + ax + (bx <<< 3) + (bx <<< 1) + (cx <<< 1) + cx;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/scharr_gradient_3x3.sv */
// ----------------------------------------------------------------------------
// scharr_gradient_3x3 - streaming 3x3 Scharr derivative
// Interleaved 8-bit raster input, interior-only dx/dy output with row and
// frame end flags.
// ----------------------------------------------------------------------------
// One sample byte is taken per clock and the block sustains that rate
// indefinitely as long as the output side is not stalled. The accept edge
// captures the sample in stage one and reads the combined two-row store
// (MAX_WIDTH*MAX_CHANNELS entries of 16 bits, one read and one write port);
// when stage one advances, the store is written back, the per-channel column
// window shifts and the result register loads. Results appear for the
// interior only, (width-2) x (height-2) pixels per channel, so the first two
// rows and the first two pixel columns of each row give no output.
// A write to any of the three register indexes restarts the frame at the
// first byte; register values are clamped to the supported range when
// written. The row store holds no reset value and needs no clearing.
`default_nettype none

module scharr_gradient_3x3 #(
  parameter int unsigned MAX_WIDTH    = scg_pkg::MaxWidthDef,
  parameter int unsigned MAX_CHANNELS = scg_pkg::MaxChannelsDef,
  parameter int unsigned MAX_HEIGHT   = scg_pkg::MaxHeightDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [scg_pkg::CfgIndexW-1:0]        cfg_index_i,
  input  logic [scg_pkg::CfgDataW-1:0]         cfg_data_i,
  // sample stream in
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [scg_pkg::PixelW-1:0]           pixel_i,
  // gradient stream out
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [scg_pkg::GradW-1:0]     grad_x_o,
  output logic signed [scg_pkg::GradW-1:0]     grad_y_o,
  output logic                                 row_last_o,
  output logic                                 frame_last_o
);

  import scg_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned WidW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HgtW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NchW  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Stage-one payload
  typedef struct packed {
    logic [PixelW-1:0] px;
    logic [AddrW-1:0]  col;
    logic [ChW-1:0]    ch;
    logic              emit;
    logic              rlast;
    logic              flast;
  } s1_t;

  // Geometry registers (clamped on write)
  logic [WidW-1:0] width_q;
  logic [HgtW-1:0] height_q;
  logic [NchW-1:0] nch_q;

  // Position counters
  logic [AddrW-1:0] col_q,  col_d;
  logic [WidW-1:0]  x_q,    x_d;
  logic [NchW-1:0]  ch_q,   ch_d;
  logic [HgtW-1:0]  row_q,  row_d;

  // Pipeline
  logic        s1_vld_q;
  s1_t         s1_q, s1_d;
  logic [2*PixelW-1:0] rd_q;
  logic        out_vld_q;
  logic signed [GradW-1:0] gx_q, gy_q;
  logic        rlast_q, flast_q;

  logic        cfg_we;
  logic        in_acc;
  logic        out_free;
  logic        s1_adv;
  logic        row_end;
  logic [31:0] cfg_ext;
  logic [31:0] nch_ext;
  logic [31:0] w_clamp, h_clamp, n_clamp;

  logic [2*PixelW-1:0] row_mem [Depth];
  win_pair_t           win_q   [MAX_CHANNELS];

  win_pair_t               win_rd;
  win_col_t                fresh;
  logic signed [GradW-1:0] gx_d, gy_d;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign s1_adv      = s1_vld_q && out_free;
  assign in_stall_o  = s1_vld_q && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Clamp of written values; the channel count keeps only its low three bits
  always_comb begin
    cfg_ext = 32'(cfg_data_i);
    nch_ext = 32'(cfg_data_i[2:0]);
    w_clamp = (cfg_ext < 32'd3) ? 32'd3 :
              (cfg_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : cfg_ext;
    h_clamp = (cfg_ext < 32'd3) ? 32'd3 :
              (cfg_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : cfg_ext;
    n_clamp = (nch_ext < 32'd1) ? 32'd1 :
              (nch_ext > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS) : nch_ext;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidW'(640 > MAX_WIDTH ? MAX_WIDTH : 640);
      height_q <= HgtW'(480 > MAX_HEIGHT ? MAX_HEIGHT : 480);
      nch_q    <= NchW'(1);
    end else if (cfg_we) begin
      case (cfg_index_i)
        RegImageWidth:   width_q  <= w_clamp[WidW-1:0];
        RegImageHeight:  height_q <= h_clamp[HgtW-1:0];
        RegChannelCount: nch_q    <= n_clamp[NchW-1:0];
        default: ;
      endcase
    end
  end

  // Position tracking and stage-one capture
  always_comb begin
    row_end = (x_q == width_q - 1'b1) && (ch_q == nch_q - 1'b1);
    col_d   = col_q;
    x_d     = x_q;
    ch_d    = ch_q;
    row_d   = row_q;
    if (row_end) begin
      col_d = '0;
      x_d   = '0;
      ch_d  = '0;
      row_d = (row_q == height_q - 1'b1) ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
      if (ch_q == nch_q - 1'b1) begin
        ch_d = '0;
        x_d  = x_q + 1'b1;
      end else begin
        ch_d = ch_q + 1'b1;
      end
    end

    s1_d.px    = pixel_i;
    s1_d.col   = col_q;
    s1_d.ch    = ch_q[ChW-1:0];
    s1_d.emit  = (row_q >= HgtW'(2)) && (x_q >= WidW'(2));
    s1_d.rlast = row_end;
    s1_d.flast = row_end && (row_q == height_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      x_q   <= '0;
      ch_q  <= '0;
      row_q <= '0;
    end else if (cfg_we &&
                 (cfg_index_i inside {RegImageWidth, RegImageHeight, RegChannelCount})) begin
      col_q <= '0;
      x_q   <= '0;
      ch_q  <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      x_q   <= x_d;
      ch_q  <= ch_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // Two-row store: {upper, middle} per byte column
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= row_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_mem[s1_q.col] <= {rd_q[PixelW-1:0], s1_q.px};
    end
  end

  // Window and kernel
  always_comb begin
    fresh.top = rd_q[2*PixelW-1:PixelW];
    fresh.mid = rd_q[PixelW-1:0];
    fresh.bot = s1_q.px;
    win_rd    = win_q[s1_q.ch];
    gx_d = kernel_sum(pix_diff(fresh.top, win_rd.left.top),
                      pix_diff(fresh.mid, win_rd.left.mid),
                      pix_diff(fresh.bot, win_rd.left.bot));
    gy_d = kernel_sum(pix_diff(win_rd.left.bot, win_rd.left.top),
                      pix_diff(win_rd.cent.bot, win_rd.cent.top),
                      pix_diff(fresh.bot, fresh.top));
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q[s1_q.ch] <= '{left: win_rd.cent, cent: fresh};
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_vld_q && s1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      gx_q    <= gx_d;
      gy_q    <= gy_d;
      rlast_q <= s1_q.rlast;
      flast_q <= s1_q.flast;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign grad_x_o     = gx_q;
  assign grad_y_o     = gy_q;
  assign row_last_o   = rlast_q;
  assign frame_last_o = flast_q;

endmodule

`default_nettype wire

/* tb/sv/scharr_gradient_3x3_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scharr_gradient_3x3_chk - predictor and comparator for the Scharr block
// Watches the register, pixel and gradient channels. Each accepted pixel
// request runs through a private copy of the row stores and column windows,
// and every interior pixel queues its expected dx/dy and end flags. Each
// accepted gradient request is compared field by field with the oldest one.
// ----------------------------------------------------------------------------

module scharr_gradient_3x3_chk (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [scg_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [scg_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [scg_pkg::PixelW-1:0]       pixel_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic signed [scg_pkg::GradW-1:0] grad_x_i,
  input  logic signed [scg_pkg::GradW-1:0] grad_y_i,
  input  logic                             row_last_i,
  input  logic                             frame_last_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  import scg_pkg::*;

  localparam int unsigned StoreDepth = MaxWidthDef * MaxChannelsDef;
  localparam int          MaxPrinted = 50;

  typedef struct packed {
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic                    row_end;
    logic                    frame_end;
  } grad_result_t;

  // shadow registers and frame position
  logic [CfgDataW-1:0] width_reg;
  logic [CfgDataW-1:0] height_reg;
  logic [2:0]          chan_reg;
  logic [11:0]         byte_col;
  logic [9:0]          row_idx;

  // shadow row stores and per-channel column windows
  logic [PixelW-1:0] upper_row [StoreDepth];
  logic [PixelW-1:0] middle_row [StoreDepth];
  win_col_t          win_left [MaxChannelsDef];
  win_col_t          win_cent [MaxChannelsDef];

  grad_result_t expected_grads[$];
  int           mismatches;

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // advance the shadow image by one byte, queue a gradient for interior pixels
  task automatic predict_gradient(input logic [PixelW-1:0] px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  nch;
    int unsigned  rb;
    int unsigned  col;
    int unsigned  ch;
    int unsigned  x;
    int unsigned  row;
    win_col_t     fresh;
    win_col_t     l;
    win_col_t     c;
    int           dx;
    int           dy;
    grad_result_t res;
    w   = clamp_to(width_reg, 3, MaxWidthDef);
    h   = clamp_to(height_reg, 3, MaxHeightDef);
    nch = clamp_to(chan_reg, 1, MaxChannelsDef);
    rb  = w * nch;
    col = byte_col;
    row = row_idx;
    if (col >= rb) col = 0;
    if (row >= h) row = 0;
    ch = col % nch;
    x  = col / nch;
    fresh.top = upper_row[col];
    fresh.mid = middle_row[col];
    fresh.bot = px;
    if (row >= 2 && x >= 2) begin
      l  = win_left[ch];
      c  = win_cent[ch];
      dx = 3 * (int'(fresh.top) - int'(l.top)) + 10 * (int'(fresh.mid) - int'(l.mid)) +
           3 * (int'(fresh.bot) - int'(l.bot));
      dy = 3 * (int'(l.bot) - int'(l.top)) + 10 * (int'(c.bot) - int'(c.top)) +
           3 * (int'(fresh.bot) - int'(fresh.top));
      res.gx        = GradW'(dx);
      res.gy        = GradW'(dy);
      res.row_end   = (col == rb - 1);
      res.frame_end = res.row_end && (row == h - 1);
      expected_grads.push_back(res);
    end
    win_left[ch]    = win_cent[ch];
    win_cent[ch]    = fresh;
    upper_row[col]  = middle_row[col];
    middle_row[col] = px;
    // counters wrap at row and frame end
    if (col + 1 >= rb) begin
      byte_col = '0;
      row_idx  = (row + 1 >= h) ? '0 : 10'(row + 1);
    end else begin
      byte_col = 12'(col + 1);
      row_idx  = 10'(row);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grad_result_t want;
    if (!rst_ni) begin
      width_reg  = 11'd640;
      height_reg = 11'd480;
      chan_reg   = 3'd1;
      byte_col   = '0;
      row_idx    = '0;
      mismatches = 0;
      expected_grads.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register write: known indexes restart the frame
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegImageWidth: begin
            width_reg = cfg_data_i;
            byte_col  = '0;
            row_idx   = '0;
          end
          RegImageHeight: begin
            height_reg = cfg_data_i;
            byte_col   = '0;
            row_idx    = '0;
          end
          RegChannelCount: begin
            chan_reg = cfg_data_i[2:0];
            byte_col = '0;
            row_idx  = '0;
          end
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) predict_gradient(pixel_i);

      // compare an accepted gradient request with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_grads.size() == 0) begin
          report("gradient with none expected, grad_x", $signed(grad_x_i), 0);
        end else begin
          want = expected_grads.pop_front();
          if (grad_x_i !== want.gx) report("grad_x", $signed(grad_x_i), want.gx);
          if (grad_y_i !== want.gy) report("grad_y", $signed(grad_y_i), want.gy);
          if (row_last_i !== want.row_end) report("row_last", row_last_i, want.row_end);
          if (frame_last_i !== want.frame_end)
            report("frame_last", frame_last_i, want.frame_end);
        end
      end

      pending_o    <= expected_grads.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* tb/sv/scharr_gradient_3x3_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scharr_gradient_3x3_tb - stimulus and verdict for the Scharr gradient block
// Directed frames hit the dx/dy extremes, register clamping, frame restart
// on write and the ignored register index; random phases then sweep small
// geometries, and two short phases cover a channel count written with high
// bits set and the upper width clamp.
// Random gaps on the pixel side and random stalls on the gradient side.
// ----------------------------------------------------------------------------

module scharr_gradient_3x3_tb;

  import scg_pkg::*;

  localparam int                 ClkPeriod    = 10;
  localparam int                 ResetCycles  = 10;
  localparam int                 DutLatency   = 2;
  localparam int                 RandomItems  = 620;
  localparam int                 CycleLimit   = 1_500_000;
  localparam logic [CfgIndexW-1:0] UnusedRegIdx = 2'd3;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIndexW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [PixelW-1:0]       pixel_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [GradW-1:0] grad_x_o;
  logic signed [GradW-1:0] grad_y_o;
  logic                    row_last_o;
  logic                    frame_last_o;

  int mismatch_count;
  int results_pending;
  int cycle_count = 0;
  int stall_left  = 0;
  bit idle_on     = 1'b1;
  bit long_ok     = 1'b1;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  scharr_gradient_3x3 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .grad_x_o    (grad_x_o),
    .grad_y_o    (grad_y_o),
    .row_last_o  (row_last_o),
    .frame_last_o(frame_last_o)
  );

  scharr_gradient_3x3_chk chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .grad_x_i    (grad_x_o),
    .grad_y_i    (grad_y_o),
    .row_last_i  (row_last_o),
    .frame_last_i(frame_last_o),
    .fail_count_o(mismatch_count),
    .pending_o   (results_pending)
  );

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    if (long_ok && $urandom_range(0, 99) < 8) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [PixelW-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return PixelW'($urandom_range(0, 255));
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!idle_on || $urandom_range(0, 99) < 60) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= idle_len() - 1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[scharr_gradient_3x3] ERROR");
      $finish;
    end
  end

  // one pixel request, optionally preceded by a gap
  task automatic send_pixel(input logic [PixelW-1:0] v);
    int gap;
    gap = (!idle_on || $urandom_range(0, 99) < 65) ? 0 : idle_len();
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  // idle point: nothing expected and the pipeline empty
  task automatic drain();
    wait_results();
    repeat (DutLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // configure, stream n random bytes, optionally pause half way until drained
  task automatic run_phase(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                           input logic [CfgDataW-1:0] c, input int n, input bit pause_mid);
    write_reg(RegImageWidth, w);
    write_reg(RegImageHeight, h);
    write_reg(RegChannelCount, c);
    if ($urandom_range(0, 3) == 0) write_reg(UnusedRegIdx, CfgDataW'($urandom));
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_results();
      send_pixel(pick_pixel());
    end
    drain();
  endtask

  initial begin
    int          random_sent;
    bit          first;
    int unsigned ew;
    int unsigned eh;
    int unsigned ec;
    bit          tall;
    int unsigned rb;
    int          n;
    logic [CfgDataW-1:0] wv;
    logic [CfgDataW-1:0] hv;
    logic [CfgDataW-1:0] cv;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a few bytes at the reset geometry, then a write restarts the frame
    for (int i = 0; i < 6; i++) send_pixel(pick_pixel());
    drain();

    // 4x3 frame, columns 255,0,0,255: both dx extremes
    write_reg(RegImageWidth, 11'd4);
    write_reg(RegImageHeight, 11'd3);
    write_reg(RegChannelCount, 11'd1);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 4; x++) send_pixel((x == 0 || x == 3) ? 8'hFF : 8'h00);
    drain();

    // width, height and channels below range clamp to a 3x3, 1-channel frame
    // (height 4 here); rows 255,0,0,255 give both dy extremes, and a write to
    // the unused index mid-frame must not restart it
    write_reg(RegImageWidth, 11'd0);
    write_reg(RegImageHeight, 11'd4);
    write_reg(RegChannelCount, 11'd0);
    for (int k = 0; k < 12; k++) begin
      if (k == 4) begin
        drain();
        write_reg(UnusedRegIdx, CfgDataW'($urandom));
      end
      send_pixel((k / 3 == 0 || k / 3 == 3) ? 8'hFF : 8'h00);
    end
    drain();

    // random small geometries
    random_sent = 0;
    first       = 1'b1;
    while (random_sent < RandomItems) begin
      ew   = $urandom_range(0, 9) == 0 ? $urandom_range(3, 12) : $urandom_range(3, 8);
      eh   = $urandom_range(3, 5);
      ec   = $urandom_range(1, 4);
      tall = ($urandom_range(0, 9) == 0);
      wv   = (ew == 3 && $urandom_range(0, 1)) ? CfgDataW'($urandom_range(0, 2)) :
             CfgDataW'(ew);
      hv   = tall ? CfgDataW'($urandom_range(1025, 2047)) :
             (eh == 3 && $urandom_range(0, 1)) ? CfgDataW'($urandom_range(0, 2)) :
             CfgDataW'(eh);
      cv   = (ec == 1 && $urandom_range(0, 1)) ? 11'd0 :
             (ec == 4 && $urandom_range(0, 1)) ? CfgDataW'($urandom_range(5, 7)) :
             CfgDataW'(ec);
      rb   = ew * ec;
      n    = rb * (tall ? 4 : eh) * $urandom_range(1, 2) + $urandom_range(0, rb);
      idle_on = first || ($urandom_range(0, 3) != 0);
      run_phase(wv, hv, cv, n, first || ($urandom_range(0, 3) == 0));
      random_sent += n;
      first = 1'b0;
    end

    // channel count with high bits set keeps its low bits (9 gives one
    // channel), then the upper width clamp; short idles only
    idle_on = 1'b1;
    long_ok = 1'b0;
    run_phase(11'd4, 11'd3, 11'd9, 16, 1'b0);
    run_phase(11'd2047, 11'd5, 11'd2, 40, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("[scharr_gradient_3x3] OK");
    end else begin
      $display("[scharr_gradient_3x3] ERROR");
    end
    $finish;
  end

endmodule
